// ===== rtl/fsge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_pkg
// shared types, request codes and sizes for the falling sand grid engine
// ----------------------------------------------------------------------------
package fsge_pkg;

    // default grid store size
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    // fixed field widths
    localparam int REQ_W     = 3;
    localparam int COORD_W   = 9;
    localparam int DIM_W     = 10;
    localparam int RAD_W     = 5;
    localparam int CFG_IDX_W = 8;
    localparam int OFS_W     = RAD_W + 1;   // signed disc offset
    localparam int SQ_W      = 2 * RAD_W;   // square of an offset

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STAMP  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_RADIUS = 8'd2;

    // configuration reset values
    localparam logic [DIM_W-1:0] RST_GRID_WIDTH   = 10'd400;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT  = 10'd300;
    localparam logic [RAD_W-1:0] RST_STAMP_RADIUS = 5'd5;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               cell_value;
    } fsge_req_t;

    typedef struct packed {
        logic read_value;
        logic status;
    } fsge_rsp_t;

    // grain move decision of one cell
    typedef struct packed {
        logic mv_down;
        logic mv_left;
        logic mv_right;
    } fsge_move_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CELL_RD,
        S_CELL_MOD,
        S_UPD_RDB,
        S_UPD_RDC,
        S_UPD_LDC,
        S_UPD_SCAN,
        S_UPD_WB,
        S_UPD_WLAST,
        S_ST_RSQ,
        S_ST_ROW,
        S_ST_ROWLD,
        S_ST_COL,
        S_ST_ROWWR,
        S_DONE
    } fsge_state_t;

endpackage

// ===== rtl/fsge_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_row_mem
// grid store, one row per word, one write and one registered read port
// ----------------------------------------------------------------------------
module fsge_row_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fsge_fall_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_fall_unit
// sand rule for one cell: down, then down-left, then down-right
// ----------------------------------------------------------------------------
module fsge_fall_unit
    import fsge_pkg::*;
(
    input  logic       active,
    input  logic       left_ok,
    input  logic       right_ok,
    input  logic       here,
    input  logic       below_dn,
    input  logic       below_dl,
    input  logic       below_dr,
    output fsge_move_t mv
);

    always_comb begin
        mv = '0;
        if (active && here) begin
            if (!below_dn) begin
                mv.mv_down = 1'b1;
            end else if (left_ok && !below_dl) begin
                mv.mv_left = 1'b1;
            end else if (right_ok && !below_dr) begin
                mv.mv_right = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/fsge_disc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsge_disc_unit
// shared squarer with add and compare for the disc coverage test
// ----------------------------------------------------------------------------
module fsge_disc_unit
    import fsge_pkg::*;
(
    input  logic signed [OFS_W-1:0] opnd,
    input  logic        [SQ_W-1:0]  addend,
    input  logic        [SQ_W-1:0]  limit,
    output logic        [SQ_W-1:0]  sq,
    output logic                    covered
);

    logic signed [2*OFS_W-1:0] prod;
    logic        [SQ_W:0]      sum;

    assign prod    = opnd * opnd;
    assign sq      = prod[SQ_W-1:0];
    assign sum     = {1'b0, sq} + {1'b0, addend};
    assign covered = (sum <= {1'b0, limit});

endmodule

// ===== rtl/falling_sand_grid_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_engine
// one-bit sand grid with cell access, clear, disc stamp and update pass
// ----------------------------------------------------------------------------
// One request at a time; s_ready is high only while the engine is idle, and
// every request returns exactly one response on the m_ channel, which is
// registered so a response may wait while the next request is taken.
// The update pass time is set by the row scan: the row under work and the
// row below sit in two shift registers that rotate one cell per cycle past
// the sand rule, and every row is rotated the full store width so it comes
// back aligned. After reset the store is swept clear, one row a cycle, before
// the first request is taken; configuration writes are taken at any time
// but must only be issued while the engine is idle.
// ----------------------------------------------------------------------------
module falling_sand_grid_engine
    import fsge_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fsge_req_t            s_data,
    // response channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output fsge_rsp_t            m_data,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    // derived sizes
    localparam int XW = $clog2(MAX_WIDTH);        // column index
    localparam int YW = $clog2(MAX_HEIGHT);       // row index
    localparam int WW = $clog2(MAX_WIDTH + 1);    // column count
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // row count
    localparam int AW = (WW > HW) ? WW : HW;
    localparam int CW = (AW > DIM_W) ? AW : DIM_W; // common compare width
    localparam int SW = CW + 2;                    // signed disc coordinates

    // state and configuration
    fsge_state_t           state_reg, state_next;
    logic [DIM_W-1:0]      grid_width_reg;
    logic [DIM_W-1:0]      grid_height_reg;
    logic [RAD_W-1:0]      stamp_radius_reg;

    // request and work registers
    fsge_req_t             req_reg, req_next;
    logic [YW-1:0]         row_reg, row_next;
    logic [XW-1:0]         x_reg, x_next;
    logic [MAX_WIDTH-1:0]  cur_reg, cur_next;
    logic [MAX_WIDTH-1:0]  below_reg, below_next;
    logic signed [OFS_W-1:0] dy_reg, dy_next;
    logic signed [OFS_W-1:0] dx_reg, dx_next;
    logic [SQ_W-1:0]       rsq_reg, rsq_next;
    logic [SQ_W-1:0]       dysq_reg, dysq_next;
    logic                  clr_resp_reg, clr_resp_next;
    fsge_rsp_t             res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    fsge_rsp_t             m_data_reg, m_data_next;

    // store ports
    logic                  mem_we;
    logic [YW-1:0]         mem_waddr;
    logic [MAX_WIDTH-1:0]  mem_wdata;
    logic [YW-1:0]         mem_raddr;
    logic [MAX_WIDTH-1:0]  mem_rdata;

    // clamped grid size
    logic [CW-1:0]         w_ext, h_ext;
    logic [WW-1:0]         w_dim;
    logic [HW-1:0]         h_dim;
    logic [HW-1:0]         hm2;

    // request decode
    logic [CW-1:0]         in_x_ext, in_y_ext;
    logic                  in_inside;

    // cell access
    logic [MAX_WIDTH-1:0]  cell_mask;
    logic [MAX_WIDTH-1:0]  rd_shift;

    // scan
    logic                  x_active, x_left, x_right, x_last;
    fsge_move_t            mv;
    logic [MAX_WIDTH-1:0]  cur_mod, below_mod;

    // stamp
    logic signed [SW-1:0]  cx_s, cy_s, nx, ny, w_s, h_s;
    logic                  row_ok, col_ok, dy_last, dx_last;
    logic signed [OFS_W-1:0] alu_opnd;
    logic [SQ_W-1:0]       alu_addend;
    logic [SQ_W-1:0]       alu_sq;
    logic                  alu_covered;

    // ------------------------------------------------------------------
    // grid store, shared disc unit and sand rule
    // ------------------------------------------------------------------
    fsge_row_mem #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (MAX_WIDTH)
    ) u_row_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fsge_disc_unit u_disc_unit (
        .opnd    (alu_opnd),
        .addend  (alu_addend),
        .limit   (rsq_reg),
        .sq      (alu_sq),
        .covered (alu_covered)
    );

    // cell x of the scan sits at bit 0, x-1 at the top bit, x+1 at bit 1
    fsge_fall_unit u_fall_unit (
        .active   ((state_reg == S_UPD_SCAN) && x_active),
        .left_ok  (x_left),
        .right_ok (x_right),
        .here     (cur_reg[0]),
        .below_dn (below_reg[0]),
        .below_dl (below_reg[MAX_WIDTH-1]),
        .below_dr (below_reg[1]),
        .mv       (mv)
    );

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg   <= RST_GRID_WIDTH;
            grid_height_reg  <= RST_GRID_HEIGHT;
            stamp_radius_reg <= RST_STAMP_RADIUS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data;
                CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_data;
                CFG_STAMP_RADIUS: stamp_radius_reg <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // grid size in use: zero counts as one, oversize counts as the store
    // ------------------------------------------------------------------
    always_comb begin
        w_ext = CW'(grid_width_reg);
        if (w_ext == '0) begin
            w_ext = CW'(1);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            w_ext = CW'(MAX_WIDTH);
        end
        h_ext = CW'(grid_height_reg);
        if (h_ext == '0) begin
            h_ext = CW'(1);
        end else if (h_ext > CW'(MAX_HEIGHT)) begin
            h_ext = CW'(MAX_HEIGHT);
        end
    end

    assign w_dim = w_ext[WW-1:0];
    assign h_dim = h_ext[HW-1:0];
    assign hm2   = h_dim - HW'(2);

    // request bounds check
    assign in_x_ext  = CW'(s_data.cell_x);
    assign in_y_ext  = CW'(s_data.cell_y);
    assign in_inside = (in_x_ext < CW'(w_dim)) && (in_y_ext < CW'(h_dim));

    // single cell access
    assign cell_mask = {{(MAX_WIDTH-1){1'b0}}, 1'b1} << req_reg.cell_x;
    assign rd_shift  = mem_rdata >> req_reg.cell_x;

    // scan position
    assign x_active = CW'(x_reg) < CW'(w_dim);
    assign x_left   = (x_reg != '0);
    assign x_right  = (CW'(x_reg) + CW'(1)) < CW'(w_dim);
    assign x_last   = (x_reg == XW'(MAX_WIDTH - 1));

    // apply the move to both row buffers before rotating
    always_comb begin
        cur_mod   = cur_reg;
        below_mod = below_reg;
        if (mv.mv_down) begin
            below_mod[0] = 1'b1;
        end
        if (mv.mv_left) begin
            below_mod[MAX_WIDTH-1] = 1'b1;
        end
        if (mv.mv_right) begin
            below_mod[1] = 1'b1;
        end
        if (mv.mv_down || mv.mv_left || mv.mv_right) begin
            cur_mod[0] = 1'b0;
        end
    end

    // disc coordinates, signed so clipping is a plain compare
    assign cx_s = $signed({{(SW-COORD_W){1'b0}}, req_reg.cell_x});
    assign cy_s = $signed({{(SW-COORD_W){1'b0}}, req_reg.cell_y});
    assign w_s  = $signed({{(SW-WW){1'b0}}, w_dim});
    assign h_s  = $signed({{(SW-HW){1'b0}}, h_dim});
    assign nx   = cx_s + $signed({{(SW-OFS_W){dx_reg[OFS_W-1]}}, dx_reg});
    assign ny   = cy_s + $signed({{(SW-OFS_W){dy_reg[OFS_W-1]}}, dy_reg});
    assign row_ok  = !ny[SW-1] && (ny < h_s);
    assign col_ok  = !nx[SW-1] && (nx < w_s);
    assign dy_last = (dy_reg == $signed({1'b0, stamp_radius_reg}));
    assign dx_last = (dx_reg == $signed({1'b0, stamp_radius_reg}));

    // shared unit operand: radius, then row offset, then column offset
    always_comb begin
        case (state_reg)
            S_ST_RSQ: alu_opnd = $signed({1'b0, stamp_radius_reg});
            S_ST_ROW: alu_opnd = dy_reg;
            default:  alu_opnd = dx_reg;
        endcase
        alu_addend = (state_reg == S_ST_COL) ? dysq_reg : '0;
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.req_type) inside
                        REQ_WRITE, REQ_READ:
                            state_next = in_inside ? S_CELL_RD : S_DONE;
                        REQ_UPDATE:
                            state_next = (h_dim < HW'(2)) ? S_DONE : S_UPD_RDB;
                        REQ_CLEAR:
                            state_next = S_CLEAR;
                        REQ_STAMP:
                            state_next = S_ST_RSQ;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (row_reg == YW'(MAX_HEIGHT - 1)) begin
                    state_next = clr_resp_reg ? S_DONE : S_IDLE;
                end
            end
            S_CELL_RD:   state_next = S_CELL_MOD;
            S_CELL_MOD:  state_next = S_DONE;
            S_UPD_RDB:   state_next = S_UPD_RDC;
            S_UPD_RDC:   state_next = S_UPD_LDC;
            S_UPD_LDC:   state_next = S_UPD_SCAN;
            S_UPD_SCAN: begin
                if (x_last) begin
                    state_next = S_UPD_WB;
                end
            end
            S_UPD_WB:    state_next = (row_reg == '0) ? S_UPD_WLAST : S_UPD_LDC;
            S_UPD_WLAST: state_next = S_DONE;
            S_ST_RSQ:    state_next = S_ST_ROW;
            S_ST_ROW: begin
                if (row_ok) begin
                    state_next = S_ST_ROWLD;
                end else if (dy_last) begin
                    state_next = S_DONE;
                end
            end
            S_ST_ROWLD:  state_next = S_ST_COL;
            S_ST_COL: begin
                if (dx_last) begin
                    state_next = S_ST_ROWWR;
                end
            end
            S_ST_ROWWR:  state_next = dy_last ? S_DONE : S_ST_ROW;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: datapath and store controls
    // ------------------------------------------------------------------
    always_comb begin
        req_next      = req_reg;
        row_next      = row_reg;
        x_next        = x_reg;
        cur_next      = cur_reg;
        below_next    = below_reg;
        dy_next       = dy_reg;
        dx_next       = dx_reg;
        rsq_next      = rsq_reg;
        dysq_next     = dysq_reg;
        clr_resp_next = clr_resp_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_we        = 1'b0;
        mem_waddr     = row_reg;
        mem_wdata     = cur_reg;
        mem_raddr     = row_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    res_next = '0;
                    unique case (s_data.req_type) inside
                        REQ_WRITE, REQ_READ: begin
                            row_next        = in_y_ext[YW-1:0];
                            res_next.status = !in_inside;
                        end
                        REQ_UPDATE: begin
                            // first row worked is second from the bottom
                            row_next = hm2[YW-1:0];
                        end
                        REQ_CLEAR: begin
                            row_next      = '0;
                            clr_resp_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                row_next  = row_reg + YW'(1);
                if (row_reg == YW'(MAX_HEIGHT - 1)) begin
                    clr_resp_next = 1'b0;
                end
            end
            S_CELL_RD: ;
            S_CELL_MOD: begin
                if (req_reg.req_type == REQ_WRITE) begin
                    mem_we    = 1'b1;
                    mem_wdata = req_reg.cell_value ? (mem_rdata | cell_mask)
                                                   : (mem_rdata & ~cell_mask);
                end else begin
                    res_next.read_value = rd_shift[0];
                end
            end
            S_UPD_RDB: begin
                mem_raddr = row_reg + YW'(1);
            end
            S_UPD_RDC: begin
                below_next = mem_rdata;
            end
            S_UPD_LDC: begin
                cur_next = mem_rdata;
                x_next   = '0;
            end
            S_UPD_SCAN: begin
                // rotate right so the next column comes to bit 0
                cur_next   = {cur_mod[0], cur_mod[MAX_WIDTH-1:1]};
                below_next = {below_mod[0], below_mod[MAX_WIDTH-1:1]};
                x_next     = x_reg + XW'(1);
            end
            S_UPD_WB: begin
                // lower row is final; worked row becomes the next lower row
                mem_we     = 1'b1;
                mem_waddr  = row_reg + YW'(1);
                mem_wdata  = below_reg;
                below_next = cur_reg;
                mem_raddr  = row_reg - YW'(1);
                if (row_reg != '0) begin
                    row_next = row_reg - YW'(1);
                end
            end
            S_UPD_WLAST: begin
                mem_we    = 1'b1;
                mem_wdata = below_reg;
            end
            S_ST_RSQ: begin
                rsq_next = alu_sq;
                dy_next  = -$signed({1'b0, stamp_radius_reg});
            end
            S_ST_ROW: begin
                dysq_next = alu_sq;
                if (row_ok) begin
                    row_next  = ny[YW-1:0];
                    mem_raddr = ny[YW-1:0];
                    dx_next   = -$signed({1'b0, stamp_radius_reg});
                end else if (!dy_last) begin
                    dy_next = dy_reg + OFS_W'(1);
                end
            end
            S_ST_ROWLD: begin
                cur_next = mem_rdata;
            end
            S_ST_COL: begin
                if (alu_covered && col_ok) begin
                    cur_next = cur_reg
                             | ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << nx[XW-1:0]);
                end
                dx_next = dx_reg + OFS_W'(1);
            end
            S_ST_ROWWR: begin
                mem_we = 1'b1;
                if (!dy_last) begin
                    dy_next = dy_reg + OFS_W'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // reset starts with a clearing sweep of the store
            state_reg    <= S_CLEAR;
            row_reg      <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        x_reg      <= x_next;
        cur_reg    <= cur_next;
        below_reg  <= below_next;
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        rsq_reg    <= rsq_next;
        dysq_reg   <= dysq_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // a taken request leaves the engine busy in the following cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one still in progress");

    // the store is never written while idle
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    // a grain takes at most one of the three paths
    a_one_move: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mv.mv_down, mv.mv_left, mv.mv_right}))
        else $error("more than one move for one grain");

    // columns beyond the width in use never move
    a_no_move_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD_SCAN) && !x_active |-> (mv == '0))
        else $error("move outside the grid width");

    // a response appears only out of the completion step
    a_resp_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside completion");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// request-level check of the falling sand grid engine
// ----------------------------------------------------------------------------
// A short directed script runs first: the empty grid after reset, far corners,
// accesses just past the edges, discs with centers inside and outside the
// grid, unused request codes, a full-store update pass, dimension clamping,
// cells hidden and shown again by a resize, and a clear. Random phases follow
// under several grid settings. A behavioral copy of the sand grid predicts
// every response, and responses are checked in order against the queue of
// predicted answers. The sender works in bursts, and the receiver stalls in
// changing patterns plus one long hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module testbench;
    import fsge_pkg::*;

    localparam int STORE_W          = MAX_WIDTH_DEF;
    localparam int STORE_H          = MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 50;
    localparam int PHASE_COUNT      = 5;
    localparam int ITEMS_PER_PHASE  = 20;

    // request codes the engine must ignore
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    // receiver stall patterns
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } sink_mode_t;

    // one line of the directed script: a register update or a request
    typedef struct packed {
        bit               set_grid;
        logic [DIM_W-1:0] grid_w;
        logic [DIM_W-1:0] grid_h;
        logic [RAD_W-1:0] radius;
        fsge_req_t        req;
        bit               known;
        fsge_rsp_t        answer;
    } script_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    fsge_req_t            s_data;
    logic                 m_valid;
    logic                 m_ready;
    fsge_rsp_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    // behavioral grid and the register values it runs under
    bit               sand_map [STORE_H][STORE_W];
    logic [DIM_W-1:0] width_setting  = RST_GRID_WIDTH;
    logic [DIM_W-1:0] height_setting = RST_GRID_HEIGHT;
    logic [RAD_W-1:0] radius_setting = RST_STAMP_RADIUS;

    // answers predicted for accepted requests, oldest first
    fsge_rsp_t   answer_q [$];
    script_row_t script_q [$];

    int  cycle_count;
    int  fail_count;
    int  answers_checked;
    int  request_count;
    int  update_count;
    int  stamp_count;
    int  outside_count;
    int  backed_up_cycles;
    int  burst_left;
    bit  hold_off_go;
    bit  hold_off_taken;

    falling_sand_grid_engine #(
        .MAX_WIDTH  (STORE_W),
        .MAX_HEIGHT (STORE_H)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // a dimension of 0 counts as 1, anything above the store counts as the store size
    function automatic int dim_in_use(input logic [DIM_W-1:0] raw, input int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    // apply one request to the behavioral grid and return its response
    function automatic fsge_rsp_t apply_request(input fsge_req_t r);
        int        w;
        int        h;
        int        rad;
        int        row;
        int        col;
        int        dx;
        int        dy;
        int        nx;
        int        ny;
        bit        in_grid;
        fsge_rsp_t a;
        w       = dim_in_use(width_setting, STORE_W);
        h       = dim_in_use(height_setting, STORE_H);
        rad     = int'(radius_setting);
        in_grid = (int'(r.cell_x) < w) && (int'(r.cell_y) < h);
        a       = '0;
        case (r.req_type)
            REQ_WRITE: begin
                if (in_grid) sand_map[r.cell_y][r.cell_x] = r.cell_value;
                else a.status = 1'b1;
            end
            REQ_READ: begin
                if (in_grid) a.read_value = sand_map[r.cell_y][r.cell_x];
                else a.status = 1'b1;
            end
            REQ_UPDATE: begin
                // in place, bottom-most movable row first, left to right
                for (row = h - 2; row >= 0; row--) begin
                    for (col = 0; col < w; col++) begin
                        if (sand_map[row][col]) begin
                            if (!sand_map[row+1][col]) begin
                                sand_map[row+1][col] = 1'b1;
                                sand_map[row][col]   = 1'b0;
                            end else if (col > 0 && !sand_map[row+1][col-1]) begin
                                sand_map[row+1][col-1] = 1'b1;
                                sand_map[row][col]     = 1'b0;
                            end else if (col + 1 < w && !sand_map[row+1][col+1]) begin
                                sand_map[row+1][col+1] = 1'b1;
                                sand_map[row][col]     = 1'b0;
                            end
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                // whole store, also outside the area in use
                for (row = 0; row < STORE_H; row++)
                    for (col = 0; col < STORE_W; col++)
                        sand_map[row][col] = 1'b0;
            end
            REQ_STAMP: begin
                for (dy = -rad; dy <= rad; dy++) begin
                    for (dx = -rad; dx <= rad; dx++) begin
                        nx = int'(r.cell_x) + dx;
                        ny = int'(r.cell_y) + dy;
                        if (nx >= 0 && nx < w && ny >= 0 && ny < h &&
                            dx * dx + dy * dy <= rad * rad)
                            sand_map[ny][nx] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic void add_req(input logic [REQ_W-1:0] code, input int x, input int y,
                                    input bit v, input bit known, input bit rd,
                                    input bit st);
        script_row_t row;
        row                  = '0;
        row.req.req_type     = code;
        row.req.cell_x       = COORD_W'(x);
        row.req.cell_y       = COORD_W'(y);
        row.req.cell_value   = v;
        row.known            = known;
        row.answer.read_value = rd;
        row.answer.status    = st;
        script_q.push_back(row);
    endfunction

    function automatic void add_grid(input int w, input int h, input int r);
        script_row_t row;
        row          = '0;
        row.set_grid = 1'b1;
        row.grid_w   = DIM_W'(w);
        row.grid_h   = DIM_W'(h);
        row.radius   = RAD_W'(r);
        script_q.push_back(row);
    endfunction

    // idle cycles before the next request: bursts of random length
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(0, 6);
        return $urandom_range(1, 6);
    endfunction

    // random request under the current grid: mostly in-grid work, some noise
    function automatic fsge_req_t random_request();
        int        w;
        int        h;
        int        reach;
        int        pick;
        fsge_req_t r;
        w    = dim_in_use(width_setting, STORE_W);
        h    = dim_in_use(height_setting, STORE_H);
        pick = $urandom_range(0, 99);
        r.cell_value = 1'($urandom_range(0, 1));
        r.cell_x     = COORD_W'($urandom_range(0, w - 1));
        r.cell_y     = COORD_W'($urandom_range(0, h - 1));
        if (pick < 22) begin
            r.req_type = REQ_WRITE;
        end else if (pick < 44) begin
            r.req_type = REQ_READ;
        end else if (pick < 56) begin
            r.req_type = REQ_UPDATE;
        end else if (pick < 66) begin
            // center may sit past the edge so the disc gets clipped
            r.req_type = REQ_STAMP;
            reach      = w + int'(radius_setting);
            r.cell_x   = COORD_W'($urandom_range(0, reach > 511 ? 511 : reach));
            reach      = h + int'(radius_setting);
            r.cell_y   = COORD_W'($urandom_range(0, reach > 511 ? 511 : reach));
        end else if (pick < 69) begin
            r.req_type = REQ_CLEAR;
        end else if (pick < 80) begin
            // anywhere in the coordinate range, mostly outside the grid
            r.req_type = pick[0] ? REQ_READ : REQ_WRITE;
            r.cell_x   = COORD_W'($urandom_range(0, 511));
            r.cell_y   = COORD_W'($urandom_range(0, 511));
        end else if (pick < 86) begin
            r.req_type = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            r.cell_x   = COORD_W'($urandom_range(0, 511));
            r.cell_y   = COORD_W'($urandom_range(0, 511));
        end else begin
            // bottom rows, where the sand piles up
            r.req_type = REQ_READ;
            r.cell_y   = COORD_W'($urandom_range(h > 3 ? h - 3 : 0, h - 1));
        end
        return r;
    endfunction

    // offer one request, hold it until taken, then predict its answer
    task automatic send_request(input fsge_req_t r, input bit known, input fsge_rsp_t typed);
        fsge_rsp_t predicted;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_request(r);
        answer_q.push_back(known ? typed : predicted);
        request_count++;
        if (r.req_type == REQ_UPDATE) update_count++;
        if (r.req_type == REQ_STAMP) stamp_count++;
        if ((known ? typed.status : predicted.status) == 1'b1) outside_count++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // stop offering and wait until every request has been answered
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
    endtask

    // write all three registers while the engine is idle
    task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [RAD_W-1:0] r);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [DIM_W-1:0]     val [3];
        int                   i;
        idx[0] = CFG_GRID_WIDTH;
        idx[1] = CFG_GRID_HEIGHT;
        idx[2] = CFG_STAMP_RADIUS;
        val[0] = w;
        val[1] = h;
        val[2] = DIM_W'(r);
        settle();
        for (i = 0; i < 3; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        width_setting  = w;
        height_setting = h;
        radius_setting = r;
    endtask

    // response checker: in order against the oldest prediction
    always @(posedge aclk) begin : check_answers
        fsge_rsp_t want;
        if (aresetn && s_valid && !s_ready && m_valid && !m_ready)
            backed_up_cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                $error("response with no request waiting: read_value %0b status %0b",
                       m_data.read_value, m_data.status);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                answers_checked++;
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value mismatch: expected %0b, got %0b",
                           want.read_value, m_data.read_value);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status mismatch: expected %0b, got %0b",
                           want.status, m_data.status);
                    fail_count++;
                end
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial begin : response_sink
        int         hold_left;
        int         mode_left;
        sink_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        mode      = SINK_OPEN;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_go && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                hold_left      = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_ready <= (mode_left % 4 == 0);
                    default:     m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        script_row_t      row;
        fsge_req_t        req;
        logic [DIM_W-1:0] pw [PHASE_COUNT];
        logic [DIM_W-1:0] ph [PHASE_COUNT];
        logic [RAD_W-1:0] pr [PHASE_COUNT];
        int               p;
        int               k;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data  = '0;

        // directed script, reset settings: 400 x 300, radius 5
        add_req(REQ_READ,        0,   0,   0, 1, 0, 0);  // empty after reset
        add_req(REQ_READ,        399, 299, 0, 1, 0, 0);  // far corner
        add_req(REQ_WRITE,       399, 299, 1, 1, 0, 0);
        add_req(REQ_READ,        399, 299, 0, 1, 1, 0);
        add_req(REQ_WRITE,       400, 5,   1, 1, 0, 1);  // one column past the edge
        add_req(REQ_READ,        5,   300, 0, 1, 0, 1);  // one row past the edge
        add_req(REQ_WRITE,       511, 511, 1, 1, 0, 1);
        add_req(REQ_STAMP,       200, 150, 0, 1, 0, 0);
        add_req(REQ_READ,        204, 153, 0, 0, 0, 0);  // on the disc rim
        add_req(REQ_STAMP,       402, 301, 1, 1, 0, 0);  // center outside, clipped
        add_req(REQ_UPDATE,      0,   0,   0, 1, 0, 0);
        add_req(REQ_READ,        399, 299, 0, 0, 0, 0);
        add_req(REQ_SPARE_FIRST, 511, 511, 1, 1, 0, 0);  // ignored code
        add_req(REQ_SPARE_LAST,  0,   0,   1, 1, 0, 0);
        // oversized dimensions clamp to the full store, largest disc
        add_grid(1023, 1023, 31);
        add_req(REQ_WRITE,       511, 511, 1, 1, 0, 0);
        add_req(REQ_STAMP,       0,   0,   0, 1, 0, 0);
        add_req(REQ_UPDATE,      0,   0,   0, 1, 0, 0);
        add_req(REQ_READ,        511, 511, 0, 0, 0, 0);
        // zero width counts as one column, single row, zero radius
        add_grid(0, 1, 0);
        add_req(REQ_READ,        511, 511, 0, 1, 0, 1);  // hidden, not lost
        add_req(REQ_STAMP,       0,   0,   0, 1, 0, 0);  // center cell only
        add_req(REQ_UPDATE,      0,   0,   0, 1, 0, 0);  // single row: no motion
        add_req(REQ_READ,        0,   0,   0, 1, 1, 0);
        // grow back: the hidden cell shows again, then clear everything
        add_grid(512, 512, 31);
        add_req(REQ_READ,        511, 511, 0, 0, 0, 0);
        add_req(REQ_CLEAR,       0,   0,   0, 1, 0, 0);
        add_req(REQ_READ,        511, 511, 0, 1, 0, 0);

        // random phases: small grid, one column, one row, full width, random
        pw[0] = 10'd16;   ph[0] = 10'd12; pr[0] = 5'd3;
        pw[1] = 10'd0;    ph[1] = 10'd8;  pr[1] = 5'd0;
        pw[2] = 10'd37;   ph[2] = 10'd0;  pr[2] = 5'd31;
        pw[3] = 10'd1023; ph[3] = 10'd6;  pr[3] = RAD_W'($urandom_range(0, 31));
        pw[4] = DIM_W'($urandom_range(2, 40));
        ph[4] = DIM_W'($urandom_range(2, 14));
        pr[4] = RAD_W'($urandom_range(0, 31));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // first request waits out the clearing sweep after reset
        while (script_q.size() != 0) begin
            row = script_q.pop_front();
            if (row.set_grid) begin
                set_grid(row.grid_w, row.grid_h, row.radius);
            end else begin
                send_request(row.req, row.known, row.answer);
                pause_sender(next_gap());
            end
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            set_grid(pw[p], ph[p], pr[p]);
            if (p == 0) begin
                // back-to-back requests into a receiver that stops taking answers
                burst_left  = 10;
                hold_off_go = 1'b1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                req = random_request();
                send_request(req, 1'b0, '0);
                pause_sender(next_gap());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d requests: %0d update passes, %0d disc stamps, %0d outside",
                 request_count, update_count, stamp_count, outside_count);
        $display("%0d responses checked in %0d cycles, %0d cycles with both sides backed up",
                 answers_checked, cycle_count, backed_up_cycles);
        if (fail_count == 0 && answer_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
